### rtl/rau_pkg.sv
// shared types, codes and constants of the rational arithmetic unit
package rau_pkg;

   // datapath word width
   localparam int WORD_BITS = 32;
   localparam int CNT_BITS  = $clog2(WORD_BITS);

   // opcode codes
   typedef logic [2:0] opcode_type;
   localparam opcode_type OP_NORM = 3'd0;
   localparam opcode_type OP_ADD  = 3'd1;
   localparam opcode_type OP_SUB  = 3'd2;
   localparam opcode_type OP_MUL  = 3'd3;
   localparam opcode_type OP_DIV  = 3'd4;
   localparam opcode_type OP_CMP  = 3'd5;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ZDEN = 2'd1,
      ST_OVF  = 2'd2
   } status_type;

   // outcome of one fraction reduction
   typedef struct packed {
      logic                        done;
      logic signed [WORD_BITS-1:0] num;
      logic [WORD_BITS-2:0]        den;
      status_type                  status;
   } red_res_type;

   // reduction sequencer
   typedef enum logic [2:0] {
      RED_IDLE,
      RED_GCD,
      RED_DIV_NUM,
      RED_DIV_DEN,
      RED_DONE
   } red_state_type;

   // top level sequencer
   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_RED_A,
      SEQ_RED_B,
      SEQ_CALC,
      SEQ_MUL0,
      SEQ_MUL1,
      SEQ_MUL2,
      SEQ_COMB,
      SEQ_RED_R
   } seq_state_type;

endpackage

### rtl/rau_reduce.sv
// fraction reduction: binary gcd and exact division on one shared subtractor
module rau_reduce (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [rau_pkg::WORD_BITS-1:0] num_val,
   input  logic signed [rau_pkg::WORD_BITS-1:0] den_val,
   output rau_pkg::red_res_type                 res
);
   import rau_pkg::*;

   localparam int W = WORD_BITS;

   red_state_type       state_ff, state_in;
   logic [W-1:0]        a_ff, a_in, b_ff, b_in;
   logic [W-1:0]        g_ff, g_in, x_ff, x_in, rem_ff, rem_in;
   logic [W-1:0]        magn_ff, magn_in, magd_ff, magd_in, qn_ff, qn_in;
   logic [CNT_BITS-1:0] k_ff, k_in, cnt_ff, cnt_in;
   logic                neg_ff, neg_in, zden_ff, zden_in;

   logic [W:0]   sub_a, sub_b;
   logic [W+1:0] diff;
   logic         borrow, qbit, ovf;
   logic [W-1:0] absdiff, quot, mag_n, mag_d;

   // operand magnitudes
   assign mag_n = num_val[W-1] ? W'(-num_val) : W'(num_val);
   assign mag_d = den_val[W-1] ? W'(-den_val) : W'(den_val);

   // shared subtractor: gcd step or restoring division step
   always_comb begin
      if (state_ff == RED_GCD) begin
         sub_a = {1'b0, a_ff};
         sub_b = {1'b0, b_ff};
      end else begin
         sub_a = {rem_ff, x_ff[W-1]};
         sub_b = {1'b0, g_ff};
      end
   end
   assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow  = diff[W+1];
   assign absdiff = borrow ? (~diff[W-1:0] + W'(1)) : diff[W-1:0];
   assign qbit    = ~borrow;
   assign quot    = {x_ff[W-2:0], qbit};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         RED_IDLE: begin
            if (start) begin
               state_in = (den_val == '0) ? RED_DONE : RED_GCD;
            end
         end
         RED_GCD: begin
            if (a_ff == '0) begin
               state_in = RED_DIV_NUM;
            end
         end
         RED_DIV_NUM: begin
            if (cnt_ff == CNT_BITS'(W-1)) begin
               state_in = RED_DIV_DEN;
            end
         end
         RED_DIV_DEN: begin
            if (cnt_ff == CNT_BITS'(W-1)) begin
               state_in = RED_DONE;
            end
         end
         RED_DONE: state_in = RED_IDLE;
         default:  state_in = RED_IDLE;
      endcase
   end

   // datapath updates
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      g_in    = g_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      magn_in = magn_ff;
      magd_in = magd_ff;
      qn_in   = qn_ff;
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      zden_in = zden_ff;
      unique case (state_ff)
         RED_IDLE: begin
            if (start) begin
               a_in    = mag_n;
               b_in    = mag_d;
               magn_in = mag_n;
               magd_in = mag_d;
               neg_in  = num_val[W-1] ^ den_val[W-1];
               zden_in = (den_val == '0);
               k_in    = '0;
            end
         end
         RED_GCD: begin
            priority if (a_ff == '0) begin
               g_in   = b_ff << k_ff;
               x_in   = magn_ff;
               rem_in = '0;
               cnt_in = '0;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + CNT_BITS'(1);
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else begin
               // both odd: keep the smaller, halve the difference
               if (borrow) begin
                  b_in = a_ff;
               end
               a_in = absdiff >> 1;
            end
         end
         RED_DIV_NUM, RED_DIV_DEN: begin
            rem_in = qbit ? diff[W-1:0] : {rem_ff[W-2:0], x_ff[W-1]};
            x_in   = quot;
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (state_ff == RED_DIV_NUM && cnt_ff == CNT_BITS'(W-1)) begin
               qn_in  = quot;
               x_in   = magd_ff;
               rem_in = '0;
               cnt_in = '0;
            end
         end
         RED_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // result
   assign ovf = x_ff[W-1] | (qn_ff[W-1] & (~neg_ff | (qn_ff[W-2:0] != '0)));

   always_comb begin
      res.done = (state_ff == RED_DONE);
      res.num  = neg_ff ? -$signed(qn_ff) : $signed(qn_ff);
      res.den  = x_ff[W-2:0];
      priority if (zden_ff) begin
         res.status = ST_ZDEN;
      end else if (ovf) begin
         res.status = ST_OVF;
      end else begin
         res.status = ST_OK;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RED_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      g_ff    <= g_in;
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      magn_ff <= magn_in;
      magd_ff <= magd_in;
      qn_ff   <= qn_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      zden_ff <= zden_in;
   end

endmodule

### rtl/rational_arith_unit_top.sv
// top level: sequencer, shared multiplier and result register of the rational unit
//
// One item at a time. An item's operands are reduced one after the other by
// a single reduction unit that runs a binary gcd (one subtract or shift per
// cycle) and then two restoring divisions, or goes straight to its result
// when the denominator is zero. Normalize needs one reduction; the other
// opcodes need two operand reductions, up to three products on the one
// 32x32 multiplier and, apart from compare, a reduction of the result. The
// next item is taken once the block is idle and the previous result has
// been taken.
module rational_arith_unit_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [2:0]                           req_opcode,
   input  logic signed [rau_pkg::WORD_BITS-1:0] req_lhs_num,
   input  logic signed [rau_pkg::WORD_BITS-1:0] req_lhs_den,
   input  logic signed [rau_pkg::WORD_BITS-1:0] req_rhs_num,
   input  logic signed [rau_pkg::WORD_BITS-1:0] req_rhs_den,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [rau_pkg::WORD_BITS-1:0] rsp_res_num,
   output logic [rau_pkg::WORD_BITS-2:0]        rsp_res_den,
   output logic                                 rsp_is_equal,
   output logic [1:0]                           rsp_status
);
   import rau_pkg::*;

   localparam int W = WORD_BITS;

   seq_state_type        state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic signed [W-1:0]  rhs_num_ff, rhs_num_in, rhs_den_ff, rhs_den_in;
   red_res_type          ra_ff, ra_in, rb_ff, rb_in;
   logic signed [W-1:0]  p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic                 povf_ff, povf_in;
   logic signed [W-1:0]  rn_ff, rn_in;
   logic                 red_start_ff, red_start_in;
   logic signed [W-1:0]  red_n_ff, red_n_in, red_d_ff, red_d_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]  out_num_ff, out_num_in;
   logic [W-2:0]         out_den_ff, out_den_in;
   logic                 out_eq_ff, out_eq_in;
   status_type           out_st_ff, out_st_in;

   red_res_type          red_res;
   logic                 req_take, rsp_take, is_norm, is_addsub;
   logic signed [W-1:0]  an, ad, bn, bd, mul_x, mul_y;
   logic signed [2*W-1:0] prod;
   logic                 prod_fits;
   logic signed [W:0]    rn_sum;
   logic                 req_is_norm;

   // reduction unit
   rau_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (red_start_ff),
      .num_val (red_n_ff),
      .den_val (red_d_ff),
      .res     (red_res)
   );

   // handshakes
   assign req_stall = (state_ff != SEQ_IDLE) | rsp_valid_ff;
   assign req_take  = req_valid & ~req_stall;
   assign rsp_take  = rsp_valid_ff & ~rsp_stall;

   assign req_is_norm = (req_opcode == OP_NORM) | (req_opcode > OP_CMP);
   assign is_norm     = (op_ff == OP_NORM) | (op_ff > OP_CMP);
   assign is_addsub   = (op_ff == OP_ADD) | (op_ff == OP_SUB);

   // reduced operands
   assign an = ra_ff.num;
   assign ad = $signed({1'b0, ra_ff.den});
   assign bn = rb_ff.num;
   assign bd = $signed({1'b0, rb_ff.den});

   // shared multiplier operand selection
   always_comb begin
      mul_x = ad;
      mul_y = bn;
      unique case (state_ff)
         SEQ_MUL0: begin
            mul_x = an;
            mul_y = (op_ff == OP_MUL) ? bn : bd;
         end
         SEQ_MUL1: begin
            mul_x = ad;
            mul_y = (op_ff == OP_MUL) ? bd : bn;
         end
         SEQ_MUL2: begin
            mul_x = ad;
            mul_y = bd;
         end
         default: begin
         end
      endcase
   end
   assign prod      = mul_x * mul_y;
   assign prod_fits = (prod[2*W-1:W-1] == '0) | (prod[2*W-1:W-1] == '1);

   // numerator combine
   always_comb begin
      if (op_ff == OP_ADD) begin
         rn_sum = {p0_ff[W-1], p0_ff} + {p1_ff[W-1], p1_ff};
      end else if (op_ff == OP_SUB) begin
         rn_sum = {p0_ff[W-1], p0_ff} - {p1_ff[W-1], p1_ff};
      end else begin
         rn_sum = {p0_ff[W-1], p0_ff};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_take) begin
               state_in = req_is_norm ? SEQ_RED_R : SEQ_RED_A;
            end
         end
         SEQ_RED_A: begin
            if (red_res.done) begin
               state_in = SEQ_RED_B;
            end
         end
         SEQ_RED_B: begin
            if (red_res.done) begin
               state_in = SEQ_CALC;
            end
         end
         SEQ_CALC: begin
            priority if (ra_ff.status != ST_OK || rb_ff.status != ST_OK) begin
               state_in = SEQ_IDLE;
            end else if (op_ff == OP_CMP) begin
               state_in = SEQ_IDLE;
            end else if (is_addsub && ra_ff.den == rb_ff.den) begin
               state_in = SEQ_COMB;
            end else begin
               state_in = SEQ_MUL0;
            end
         end
         SEQ_MUL0: state_in = SEQ_MUL1;
         SEQ_MUL1: state_in = is_addsub ? SEQ_MUL2 : SEQ_COMB;
         SEQ_MUL2: state_in = SEQ_COMB;
         SEQ_COMB: begin
            if (povf_ff || (rn_sum[W] != rn_sum[W-1])) begin
               state_in = SEQ_IDLE;
            end else begin
               state_in = SEQ_RED_R;
            end
         end
         SEQ_RED_R: begin
            if (red_res.done) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // datapath and result loading
   always_comb begin
      op_in        = op_ff;
      rhs_num_in   = rhs_num_ff;
      rhs_den_in   = rhs_den_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      p0_in        = p0_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      povf_in      = povf_ff;
      rn_in        = rn_ff;
      red_start_in = 1'b0;
      red_n_in     = red_n_ff;
      red_d_in     = red_d_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_take;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      out_eq_in    = out_eq_ff;
      out_st_in    = out_st_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_take) begin
               op_in        = req_opcode;
               rhs_num_in   = req_rhs_num;
               rhs_den_in   = req_rhs_den;
               rn_in        = req_lhs_num;
               red_start_in = 1'b1;
               red_n_in     = req_lhs_num;
               red_d_in     = req_lhs_den;
            end
         end
         SEQ_RED_A: begin
            if (red_res.done) begin
               ra_in        = red_res;
               red_start_in = 1'b1;
               red_n_in     = rhs_num_ff;
               red_d_in     = rhs_den_ff;
            end
         end
         SEQ_RED_B: begin
            if (red_res.done) begin
               rb_in = red_res;
            end
         end
         SEQ_CALC: begin
            povf_in = 1'b0;
            p0_in   = an;
            p1_in   = bn;
            p2_in   = ad;
            out_num_in = '0;
            out_den_in = '0;
            out_eq_in  = 1'b0;
            priority if (ra_ff.status == ST_ZDEN || rb_ff.status == ST_ZDEN) begin
               rsp_valid_in = 1'b1;
               out_st_in    = ST_ZDEN;
            end else if (ra_ff.status != ST_OK || rb_ff.status != ST_OK) begin
               rsp_valid_in = 1'b1;
               out_st_in    = ST_OVF;
            end else if (op_ff == OP_CMP) begin
               rsp_valid_in = 1'b1;
               out_eq_in    = (ra_ff.num == rb_ff.num) & (ra_ff.den == rb_ff.den);
               out_st_in    = ST_OK;
            end else begin
            end
         end
         SEQ_MUL0: begin
            p0_in   = prod[W-1:0];
            povf_in = povf_ff | ~prod_fits;
         end
         SEQ_MUL1: begin
            p1_in   = prod[W-1:0];
            povf_in = povf_ff | ~prod_fits;
         end
         SEQ_MUL2: begin
            p2_in   = prod[W-1:0];
            povf_in = povf_ff | ~prod_fits;
         end
         SEQ_COMB: begin
            if (povf_ff || (rn_sum[W] != rn_sum[W-1])) begin
               rsp_valid_in = 1'b1;
               out_num_in   = '0;
               out_den_in   = '0;
               out_eq_in    = 1'b0;
               out_st_in    = ST_OVF;
            end else begin
               rn_in        = rn_sum[W-1:0];
               red_start_in = 1'b1;
               red_n_in     = rn_sum[W-1:0];
               red_d_in     = is_addsub ? p2_ff : p1_ff;
            end
         end
         SEQ_RED_R: begin
            if (red_res.done) begin
               rsp_valid_in = 1'b1;
               out_eq_in    = 1'b0;
               out_st_in    = red_res.status;
               unique case (red_res.status)
                  ST_OK: begin
                     out_num_in = red_res.num;
                     out_den_in = red_res.den;
                  end
                  ST_ZDEN: begin
                     // zero denominator passes the numerator on unreduced
                     out_num_in = rn_ff;
                     out_den_in = '0;
                  end
                  default: begin
                     out_num_in = '0;
                     out_den_in = '0;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
      if (is_norm && state_ff == SEQ_CALC) begin
         rsp_valid_in = rsp_valid_ff & ~rsp_take;
      end
   end

   // outputs
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = out_num_ff;
   assign rsp_res_den  = out_den_ff;
   assign rsp_is_equal = out_eq_ff;
   assign rsp_status   = out_st_ff;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         red_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         red_start_ff <= red_start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      rhs_num_ff <= rhs_num_in;
      rhs_den_ff <= rhs_den_in;
      ra_ff      <= ra_in;
      rb_ff      <= rb_in;
      p0_ff      <= p0_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      povf_ff    <= povf_in;
      rn_ff      <= rn_in;
      red_n_ff   <= red_n_in;
      red_d_ff   <= red_d_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_eq_ff  <= out_eq_in;
      out_st_ff  <= out_st_in;
   end

endmodule

### tb/tb.sv
// self-checking testbench of the rational arithmetic unit
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   localparam longint WMAX = 64'sd2147483647;
   localparam longint WMIN = -64'sd2147483648;

   // one operation and its expected outcome
   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] lhs_num;
      logic [31:0] lhs_den;
      logic [31:0] rhs_num;
      logic [31:0] rhs_den;
   } op_item_type;

   typedef struct packed {
      logic [31:0] num;
      logic [30:0] den;
      logic        eq;
      logic [1:0]  status;
   } fraction_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_opcode = '0;
   logic signed [31:0] req_lhs_num = '0, req_lhs_den = '0, req_rhs_num = '0, req_rhs_den = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic signed [31:0] rsp_res_num;
   logic [30:0] rsp_res_den;
   logic rsp_is_equal;
   logic [1:0] rsp_status;

   op_item_type      pending_ops[$];
   fraction_res_type expected_fracs[$];
   int  n_mismatch = 0;
   bit  stim_done = 1'b0;
   bit  hold_off = 1'b0;
   int  sent_count = 0;
   bit  req_fire = 1'b0;
   bit  rsp_fire = 1'b0;

   rational_arith_unit_top dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // handshakes seen at the rising edge
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
   end

   // magnitude gcd
   function automatic longint unsigned gcd_mag(longint unsigned a, longint unsigned b);
      longint unsigned r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   // reduce a fraction in place, returns status
   function automatic status_type reduce_frac(inout longint n, inout longint d);
      longint unsigned g;
      if (d == 0) return ST_ZDEN;
      g = gcd_mag(n < 0 ? -n : n, d < 0 ? -d : d);
      n = n / longint'(g);
      d = d / longint'(g);
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      if (n < WMIN || n > WMAX || d > WMAX) return ST_OVF;
      return ST_OK;
   endfunction

   function automatic bit in_word(longint v);
      return v >= WMIN && v <= WMAX;
   endfunction

   function automatic fraction_res_type pack_res(longint n, longint d, bit eq, status_type st);
      fraction_res_type r;
      r.num = n[31:0];
      r.den = d[30:0];
      r.eq = eq;
      r.status = st;
      return r;
   endfunction

   // predicted outcome of one operation
   function automatic fraction_res_type fraction_outcome(op_item_type it);
      longint an, ad, bn, bd, rn, rd, p1, p2, n0;
      status_type sa, sb, st;
      an = longint'(signed'(it.lhs_num));
      ad = longint'(signed'(it.lhs_den));
      bn = longint'(signed'(it.rhs_num));
      bd = longint'(signed'(it.rhs_den));
      if (it.opcode == OP_NORM || it.opcode > OP_CMP) begin
         n0 = an;
         st = reduce_frac(an, ad);
         if (st == ST_ZDEN) return pack_res(n0, 0, 0, ST_ZDEN);
         if (st == ST_OVF) return pack_res(0, 0, 0, ST_OVF);
         return pack_res(an, ad, 0, ST_OK);
      end
      sa = reduce_frac(an, ad);
      sb = reduce_frac(bn, bd);
      if (sa == ST_ZDEN || sb == ST_ZDEN) return pack_res(0, 0, 0, ST_ZDEN);
      if (sa == ST_OVF || sb == ST_OVF) return pack_res(0, 0, 0, ST_OVF);
      if (it.opcode == OP_CMP) return pack_res(0, 0, an == bn && ad == bd, ST_OK);
      if (it.opcode == OP_ADD || it.opcode == OP_SUB) begin
         if (ad == bd) begin
            rn = (it.opcode == OP_ADD) ? an + bn : an - bn;
            rd = ad;
         end else begin
            p1 = an * bd;
            p2 = bn * ad;
            rd = ad * bd;
            if (!in_word(p1) || !in_word(p2) || !in_word(rd)) return pack_res(0, 0, 0, ST_OVF);
            rn = (it.opcode == OP_ADD) ? p1 + p2 : p1 - p2;
         end
      end else if (it.opcode == OP_MUL) begin
         rn = an * bn;
         rd = ad * bd;
      end else begin
         rn = an * bd;
         rd = ad * bn;
      end
      if (!in_word(rn) || !in_word(rd)) return pack_res(0, 0, 0, ST_OVF);
      p1 = rn;
      st = reduce_frac(rn, rd);
      if (st == ST_ZDEN) return pack_res(p1, 0, 0, ST_ZDEN);
      if (st == ST_OVF) return pack_res(0, 0, 0, ST_OVF);
      return pack_res(rn, rd, 0, ST_OK);
   endfunction

   // random operand value, mostly small, sometimes wide
   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h8000_0000 ^ $urandom_range(0, 3);
         2: return 32'h7fff_ffff - $urandom_range(0, 3);
         3: return 32'(-$urandom_range(0, 1000));
         4: return 32'($urandom_range(0, 65535));
         5: return 32'(-$urandom_range(0, 65535));
         6: return 32'($urandom_range(0, 2));
         default: return 32'($urandom_range(1, 60)) * (($urandom_range(0, 1) != 0) ? 1 : -1);
      endcase
   endfunction

   task automatic queue_op(logic [2:0] op, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d);
      op_item_type it;
      it.opcode = op;
      it.lhs_num = a;
      it.lhs_den = b;
      it.rhs_num = c;
      it.rhs_den = d;
      pending_ops.push_back(it);
   endtask

   // stimulus
   initial begin
      op_item_type it;
      logic [31:0] x;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      // directed: every opcode, extremes, zero denominators, overflow
      queue_op(OP_NORM, 6, -4, 0, 0);
      queue_op(OP_NORM, 0, 7, 0, 0);
      queue_op(OP_NORM, 0, 0, 0, 0);
      queue_op(OP_NORM, 32'h8000_0000, 32'hffff_ffff, 0, 0);
      queue_op(OP_NORM, 32'h8000_0000, 32'h8000_0000, 5, 5);
      queue_op(OP_NORM, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
      queue_op(OP_ADD, 1, 3, 1, 6);
      queue_op(OP_ADD, 1, 4, 3, 4);
      queue_op(OP_SUB, 1, 2, 1, 2);
      queue_op(OP_SUB, 5, -7, 2, 3);
      queue_op(OP_MUL, -2, 3, 9, 4);
      queue_op(OP_MUL, 32'h7fff_ffff, 1, 2, 1);
      queue_op(OP_DIV, 3, 4, -9, 8);
      queue_op(OP_DIV, 3, 4, 0, 5);
      queue_op(OP_CMP, 2, 4, -1, -2);
      queue_op(OP_CMP, 2, 4, 1, 3);
      queue_op(OP_CMP, 1, 0, 1, 1);
      queue_op(OP_ADD, 1, 32'h7fff_fff0, 1, 32'h7fff_ffef);
      queue_op(OP_ADD, 1, 0, 1, 1);
      queue_op(3'd6, 10, 4, 1, 1);
      queue_op(3'd7, -9, 3, 1, 1);
      queue_op(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 1);
      for (int i = 0; i < 400; i++) begin
         it.opcode = 3'($urandom_range(0, 7));
         it.lhs_num = rand_word();
         it.lhs_den = rand_word();
         it.rhs_num = rand_word();
         it.rhs_den = rand_word();
         if ($urandom_range(0, 3) == 0) begin
            x = $urandom();
            it.lhs_num = x;
            it.rhs_num = ~x;
         end
         pending_ops.push_back(it);
      end
      stim_done = 1'b1;
   end

   // driver
   always @(negedge clock) begin
      static int gap = 0;
      op_item_type it;
      if (!reset) begin
         if (req_fire) begin
            it = pending_ops.pop_front();
            expected_fracs.push_back(fraction_outcome(it));
            sent_count++;
            gap = $urandom_range(0, 10);
            if (sent_count % 3 == 0) gap = 0;
         end
         if (!req_valid || req_fire) begin
            if (gap > 0) begin
               gap--;
               req_valid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               it = pending_ops[0];
               req_valid <= 1'b1;
               req_opcode <= it.opcode;
               req_lhs_num <= it.lhs_num;
               req_lhs_den <= it.lhs_den;
               req_rhs_num <= it.rhs_num;
               req_rhs_den <= it.rhs_den;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off while the driver keeps offering items
   initial begin
      wait (sent_count == 30);
      hold_off = 1'b1;
      repeat (3000) @(posedge clock);
      hold_off = 1'b0;
   end

   // receiver stall
   always @(negedge clock) begin
      static int wait_cnt = 0;
      if (reset || hold_off) begin
         rsp_stall <= 1'b1;
      end else if (rsp_fire) begin
         wait_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
         rsp_stall <= (wait_cnt != 0);
      end else if (wait_cnt > 0) begin
         wait_cnt--;
         rsp_stall <= (wait_cnt != 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      fraction_res_type e;
      fraction_res_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_res_num, rsp_res_den, rsp_is_equal, rsp_status};
         if (expected_fracs.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10)
               $display("unexpected item: num %0d den %0d eq %0b status %0d",
                        rsp_res_num, rsp_res_den, rsp_is_equal, rsp_status);
         end else begin
            e = expected_fracs.pop_front();
            if (got !== e) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display({"mismatch: expected num %0d den %0d eq %0b status %0d, ",
                            "got num %0d den %0d eq %0b status %0d"},
                           $signed(e.num), e.den, e.eq, e.status,
                           rsp_res_num, rsp_res_den, rsp_is_equal, rsp_status);
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done && pending_ops.size() == 0 && !req_valid && expected_fracs.size() == 0);
      repeat (500) @(posedge clock);
      if (n_mismatch == 0 && expected_fracs.size() == 0)
         $display("rational_arith_unit_top regression: pass");
      else
         $display("rational_arith_unit_top regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("rational_arith_unit_top regression: fail");
      $finish;
   end
endmodule
